/* design/radix4_fft_dit_top_assert.svh */
// assertion macros for the radix-4 fft block
`ifndef RADIX4_FFT_DIT_TOP_ASSERT_SVH
`define RADIX4_FFT_DIT_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define R4_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("r4 check failed");
`define R4_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("r4 check failed");
`else
`define R4_ASSERT_IMPL(label, clk, rst, a, c)
`define R4_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

/* design/r4fft_pkg.sv */
package r4fft_pkg;
  localparam int Points = 64;
  localparam int AddrBits = 6;
  localparam int Stages = 3;
  localparam int SampleBits = 16;
  localparam int TwBits = 16;
  localparam int ResBits = 22;
  localparam int LaneBits = ResBits + 2;
  localparam int AccBits = ResBits + 4;
  localparam int ProdBits = ResBits + TwBits + 1;
  localparam logic signed [ProdBits-1:0] ProdRound = ProdBits'(1) <<< (TwBits - 2);

  // cycle slots within one butterfly
  localparam logic [3:0] SlotMul = 4'd4;
  localparam logic [3:0] SlotSum = 4'd5;
  localparam logic [3:0] SlotWrite = 4'd6;
  localparam logic [3:0] SlotLast = 4'd9;

  typedef logic signed [ResBits-1:0] res_t;
  typedef logic signed [LaneBits-1:0] lane_t;
  typedef logic signed [AccBits-1:0] acc_t;
  typedef logic signed [TwBits-1:0] tw_t;
  typedef logic [AddrBits-1:0] addr_t;

  typedef struct packed {
    logic load_we;
    logic rd_en;
    addr_t rd_addr;
    logic [1:0] lane;
    addr_t tw_m;
    logic sum_en;
    logic wr_en;
    logic [1:0] wr_lane;
    addr_t wr_addr;
  } cmd_t;

  function automatic logic signed [16:0] cos_q(input logic [5:0] m);
    logic signed [16:0] t [17];
    logic signed [16:0] v;
    t = '{17'sd32768, 17'sd32610, 17'sd32138, 17'sd31357, 17'sd30274, 17'sd28899,
          17'sd27246, 17'sd25330, 17'sd23170, 17'sd20788, 17'sd18205, 17'sd15447,
          17'sd12540, 17'sd9512, 17'sd6393, 17'sd3212, 17'sd0};
    v = '0;
    if (m <= 6'd16) v = t[m[4:0]];
    else if (m <= 6'd32) v = -t[5'(6'd32 - m)];
    else if (m <= 6'd48) v = -t[5'(m - 6'd32)];
    else v = t[5'(7'd64 - {1'b0, m})];
    return v;
  endfunction

  function automatic tw_t tw_sat(input logic signed [16:0] v);
    tw_t r;
    if (v > 17'sd32767) r = 16'sh7fff;
    else if (v < -17'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  function automatic res_t sat(input acc_t v);
    res_t r;
    if (v > AccBits'(2**(ResBits-1)-1)) r = {1'b0, {(ResBits-1){1'b1}}};
    else if (v < -AccBits'(2**(ResBits-1))) r = {1'b1, {(ResBits-1){1'b0}}};
    else r = v[ResBits-1:0];
    return r;
  endfunction

  function automatic addr_t digit_rev(input addr_t a);
    return {a[1:0], a[3:2], a[5:4]};
  endfunction
endpackage

/* design/r4fft_if.sv */
interface r4fft_in_if (input logic clk);
  logic valid;
  logic ready;
  logic signed [r4fft_pkg::SampleBits-1:0] sample_re;
  logic signed [r4fft_pkg::SampleBits-1:0] sample_im;
  modport source (output valid, sample_re, sample_im, input ready);
  modport sink (input valid, sample_re, sample_im, output ready);
endinterface

interface r4fft_out_if (input logic clk);
  logic valid;
  logic ready;
  r4fft_pkg::res_t bin_re;
  r4fft_pkg::res_t bin_im;
  r4fft_pkg::addr_t bin_index;
  logic frame_last;
  modport source (output valid, bin_re, bin_im, bin_index, frame_last, input ready);
  modport sink (input valid, bin_re, bin_im, bin_index, frame_last, output ready);
endinterface

/* design/r4fft_datapath.sv */
module r4fft_datapath (
  input  logic clk,
  input  r4fft_pkg::cmd_t cmd,
  input  r4fft_pkg::addr_t load_addr,
  input  logic signed [r4fft_pkg::SampleBits-1:0] load_re,
  input  logic signed [r4fft_pkg::SampleBits-1:0] load_im,
  output r4fft_pkg::res_t rd_re,
  output r4fft_pkg::res_t rd_im
);
  r4fft_pkg::res_t mem_re [r4fft_pkg::Points];
  r4fft_pkg::res_t mem_im [r4fft_pkg::Points];
  r4fft_pkg::lane_t lr [4];
  r4fft_pkg::lane_t li [4];
  r4fft_pkg::acc_t xr [4];
  r4fft_pkg::acc_t xi [4];
  r4fft_pkg::res_t tr [4];
  r4fft_pkg::res_t ti [4];
  logic signed [r4fft_pkg::ProdBits-1:0] pr, pi;
  r4fft_pkg::tw_t wr, wi;
  logic [1:0] lane_d;
  logic rd_en_d;
  r4fft_pkg::addr_t m_d;

  // reads are registered; twiddle index and lane aligned with read data
  always_ff @(posedge clk) begin
    if (cmd.load_we) begin
      mem_re[load_addr] <= r4fft_pkg::res_t'(load_re);
      mem_im[load_addr] <= r4fft_pkg::res_t'(load_im);
    end else if (cmd.wr_en) begin
      mem_re[cmd.wr_addr] <= tr[cmd.wr_lane];
      mem_im[cmd.wr_addr] <= ti[cmd.wr_lane];
    end
    rd_re <= mem_re[cmd.rd_addr];
    rd_im <= mem_im[cmd.rd_addr];
    lane_d <= cmd.lane;
    rd_en_d <= cmd.rd_en;
    m_d <= cmd.tw_m;
  end

  always_comb begin
    wr = r4fft_pkg::tw_sat(r4fft_pkg::cos_q(m_d));
    wi = r4fft_pkg::tw_sat(-r4fft_pkg::cos_q(6'(m_d + 6'd48)));
    pr = r4fft_pkg::ProdBits'(rd_re) * r4fft_pkg::ProdBits'(wr)
       - r4fft_pkg::ProdBits'(rd_im) * r4fft_pkg::ProdBits'(wi) + r4fft_pkg::ProdRound;
    pi = r4fft_pkg::ProdBits'(rd_re) * r4fft_pkg::ProdBits'(wi)
       + r4fft_pkg::ProdBits'(rd_im) * r4fft_pkg::ProdBits'(wr) + r4fft_pkg::ProdRound;
  end

  // twiddled lane values (lane 0 passes through), two bits of headroom
  always_ff @(posedge clk) begin
    if (rd_en_d) begin
      if (lane_d == 2'd0) begin
        lr[0] <= r4fft_pkg::lane_t'(rd_re);
        li[0] <= r4fft_pkg::lane_t'(rd_im);
      end else begin
        lr[lane_d] <= r4fft_pkg::lane_t'(pr >>> (r4fft_pkg::TwBits-1));
        li[lane_d] <= r4fft_pkg::lane_t'(pi >>> (r4fft_pkg::TwBits-1));
      end
    end
  end

  always_comb begin
    for (int n = 0; n < 4; n++) begin
      xr[n] = r4fft_pkg::acc_t'(lr[n]);
      xi[n] = r4fft_pkg::acc_t'(li[n]);
    end
  end

  // butterfly sums once all four lanes are in, written back lane by lane
  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      tr[0] <= r4fft_pkg::sat(xr[0] + xr[1] + xr[2] + xr[3]);
      ti[0] <= r4fft_pkg::sat(xi[0] + xi[1] + xi[2] + xi[3]);
      tr[1] <= r4fft_pkg::sat(xr[0] + xi[1] - xr[2] - xi[3]);
      ti[1] <= r4fft_pkg::sat(xi[0] - xr[1] - xi[2] + xr[3]);
      tr[2] <= r4fft_pkg::sat(xr[0] - xr[1] + xr[2] - xr[3]);
      ti[2] <= r4fft_pkg::sat(xi[0] - xi[1] + xi[2] - xi[3]);
      tr[3] <= r4fft_pkg::sat(xr[0] - xi[1] - xr[2] + xi[3]);
      ti[3] <= r4fft_pkg::sat(xi[0] + xr[1] - xi[2] - xr[3]);
    end
  end
endmodule

/* design/r4fft_ctrl.sv */
`include "radix4_fft_dit_top_assert.svh"
module r4fft_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic out_ready,
  output logic in_ready,
  output logic out_valid,
  output r4fft_pkg::addr_t load_addr,
  output r4fft_pkg::addr_t out_index,
  output r4fft_pkg::cmd_t cmd
);
  typedef enum logic [3:0] {
    S_LOAD = 4'b0001,
    S_BFLY = 4'b0010,
    S_EMIT = 4'b0100,
    S_HOLD = 4'b1000
  } state_t;

  state_t state;
  r4fft_pkg::addr_t count;
  logic [1:0] stage;
  logic [3:0] grp;
  logic [3:0] sub;
  logic [1:0] wl;

  // address of one lane of butterfly grp in stage
  function automatic r4fft_pkg::addr_t lane_addr(input logic [1:0] st, input logic [3:0] g,
                                                 input logic [1:0] ln);
    r4fft_pkg::addr_t a;
    unique case (st)
      2'd0: a = {g, ln};
      2'd1: a = {g[3:2], ln, g[1:0]};
      default: a = {ln, g};
    endcase
    return a;
  endfunction

  // twiddle index k * step * lane, below 64
  function automatic r4fft_pkg::addr_t tw_index(input logic [1:0] st, input logic [3:0] g,
                                                input logic [1:0] ln);
    logic [5:0] k6;
    logic [5:0] s6;
    logic [5:0] l6;
    l6 = {4'd0, ln};
    unique case (st)
      2'd0: begin
        k6 = '0;
        s6 = 6'd16;
      end
      2'd1: begin
        k6 = {4'd0, g[1:0]};
        s6 = 6'd4;
      end
      default: begin
        k6 = {2'd0, g};
        s6 = 6'd1;
      end
    endcase
    return k6 * s6 * l6;
  endfunction

  assign in_ready = (state == S_LOAD);
  assign load_addr = r4fft_pkg::digit_rev(count);

  always_comb begin
    wl = 2'(sub - r4fft_pkg::SlotWrite);
    cmd = '0;
    cmd.load_we = in_fire;
    if (state == S_BFLY) begin
      if (sub < r4fft_pkg::SlotMul) begin
        cmd.rd_en = 1'b1;
        cmd.lane = sub[1:0];
        cmd.rd_addr = lane_addr(stage, grp, sub[1:0]);
        cmd.tw_m = tw_index(stage, grp, sub[1:0]);
      end
      cmd.sum_en = (sub == r4fft_pkg::SlotSum);
      if (sub >= r4fft_pkg::SlotWrite) begin
        cmd.wr_en = 1'b1;
        cmd.wr_lane = wl;
        cmd.wr_addr = lane_addr(stage, grp, wl);
      end
    end else if (state == S_EMIT || state == S_HOLD) begin
      cmd.rd_addr = (state == S_HOLD && out_ready) ? 6'(out_index + 6'd1) : out_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      stage <= '0;
      grp <= '0;
      sub <= '0;
      out_index <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_fire) begin
            count <= 6'(count + 6'd1);
            if (count == 6'(r4fft_pkg::Points - 1)) begin
              state <= S_BFLY;
              stage <= '0;
              grp <= '0;
              sub <= '0;
            end
          end
        end
        S_BFLY: begin
          // 4 reads, multiply, sums, 4 writebacks
          if (sub == r4fft_pkg::SlotLast) begin
            sub <= '0;
            grp <= 4'(grp + 4'd1);
            if (grp == 4'(r4fft_pkg::Points / 4 - 1)) begin
              if (stage == 2'(r4fft_pkg::Stages - 1)) begin
                state <= S_EMIT;
                out_index <= '0;
              end else begin
                stage <= 2'(stage + 2'd1);
              end
            end
          end else begin
            sub <= 4'(sub + 4'd1);
          end
        end
        S_EMIT: begin
          state <= S_HOLD;
          out_valid <= 1'b1;
        end
        S_HOLD: begin
          if (out_ready) begin
            out_index <= 6'(out_index + 6'd1);
            if (out_index == 6'(r4fft_pkg::Points - 1)) begin
              out_valid <= 1'b0;
              state <= S_LOAD;
              count <= '0;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  `R4_ASSERT_IMPL(a_no_load_busy, clk, rst, state != S_LOAD, !in_ready)
  `R4_ASSERT_IMPL(a_valid_hold, clk, rst, out_valid, state == S_HOLD)
  `R4_ASSERT_NEXT(a_frame_start, clk, rst, in_fire && count == 6'd63, state == S_BFLY)
endmodule

/* design/radix4_fft_dit_top.sv */
// radix-4 decimation-in-time fft, 64 complex points
// input channel: one sample (sample_re, sample_im) per item, natural order,
// stored at its base-4 digit-reversed address
// after the 64th item the block runs 3 stages of 16 radix-4 butterflies in
// place; each butterfly takes 4 memory reads through one shared complex
// multiplier, a multiply step, a sum step and 4 writebacks
// output channel: 64 bins in natural order with bin_index and frame_last
// marking bin 63, at most one bin per cycle out of the registered memory
// read port; the first bin is offered once the last butterfly is written back
// input ready is low from the last sample until the last bin is taken
// a stalled receiver simply holds the current bin; nothing is lost
// with no stalls most of a frame is spent in the butterfly loop
// reset is synchronous, active high; it returns to loading at sample 0
// results are unscaled, saturated to 22 bits signed after each stage
module radix4_fft_dit_top (
  input logic clk,
  input logic rst,
  r4fft_in_if.sink in_ch,
  r4fft_out_if.source out_ch
);
  r4fft_pkg::cmd_t cmd;
  r4fft_pkg::addr_t load_addr;
  r4fft_pkg::addr_t out_index;
  r4fft_pkg::res_t rd_re, rd_im;
  logic in_fire;

  assign in_fire = in_ch.valid & in_ch.ready;

  r4fft_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_ready(out_ch.ready),
    .in_ready(in_ch.ready), .out_valid(out_ch.valid), .load_addr(load_addr),
    .out_index(out_index), .cmd(cmd)
  );

  r4fft_datapath u_dp (
    .clk(clk), .cmd(cmd), .load_addr(load_addr),
    .load_re(in_ch.sample_re), .load_im(in_ch.sample_im),
    .rd_re(rd_re), .rd_im(rd_im)
  );

  assign out_ch.bin_re = rd_re;
  assign out_ch.bin_im = rd_im;
  assign out_ch.bin_index = out_index;
  assign out_ch.frame_last = (out_index == 6'(r4fft_pkg::Points - 1));
endmodule
